### src/bscl_pkg.sv
// ----------------------------------------------------------------------------
// bscl_pkg
// Shared types, widths, codes and the softplus table of the balanced sigmoid
// cross-entropy loss block.
// ----------------------------------------------------------------------------
`default_nettype none

package bscl_pkg;

  localparam int PIXEL_W   = 16;
  localparam int CH_W      = 4;
  localparam int LABEL_W   = 5;
  localparam int CFG_W     = 5;
  localparam int LOGIT_W   = 16;
  localparam int PROB_W    = 16;
  localparam int SCALE_W   = 16;
  localparam int CNT_W     = 17;
  localparam int WEIGHT_W  = 17;
  localparam int SUM_W     = 40;
  localparam int GRAD_W    = 32;
  localparam int LOSS_W    = 48;
  localparam int SP_W      = 16;
  localparam int SP_DEPTH  = 256;

  localparam int MAX_PIXELS_DEF = 65536;
  localparam int MAX_CHANNELS   = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CFG_W-1:0] CHANNELS_RST = CFG_W'(1);

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_FWD  = 2'd1,
    FUNC_BWD  = 2'd2
  } func_e;

  localparam logic KIND_GRAD = 1'b0;
  localparam logic KIND_LOSS = 1'b1;

  typedef struct packed {
    logic [1:0]                func;
    logic [PIXEL_W-1:0]        pixel;
    logic [CH_W-1:0]           channel;
    logic [LABEL_W-1:0]        label;
    logic signed [LOGIT_W-1:0] logit;
    logic [PROB_W-1:0]         prob;
    logic signed [SCALE_W-1:0] loss_scale;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [GRAD_W-1:0] gradient;
    logic [LOSS_W-1:0]        loss;
  } result_t;

  typedef struct packed {
    logic                start;
    logic [CNT_W-1:0]    numer;
    logic [CNT_W-1:0]    denom;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] quot;
  } div_rsp_t;

  typedef logic [SP_DEPTH-1:0][SP_W-1:0] sp_table_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Shift-subtract quotient, used only while the table is elaborated.
  function automatic logic [63:0] sp_quot(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1+y) = 2*atanh(y/(2+y)), y in Q2.30, result in Q0.16
  function automatic logic [SP_W-1:0] sp_ln1p(input logic [63:0] y);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] r;
    z   = sp_quot(y << 30, (Q30_ONE << 1) + y);
    z2  = (z * z) >> 30;
    p   = z;
    acc = '0;
    for (int n = 1; n < 200; n += 2) begin
      if (p != 64'd0) begin
        acc = acc + sp_quot(p, 64'(n));
        p   = (p * z2) >> 30;
      end
    end
    r = ((acc << 1) + (64'd1 << 13)) >> 14;
    return (r > 64'd65535) ? SP_W'(65535) : r[SP_W-1:0];
  endfunction

  // Entry k holds ln(1+exp(-k/16)) in Q0.16.
  function automatic sp_table_t sp_build();
    sp_table_t   tbl;
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] y;
    e    = Q30_ONE;
    term = Q30_ONE;
    y    = Q30_ONE;
    for (int n = 1; n <= 12; n++) begin
      term = sp_quot(term, 64'(16 * n));
      if ((n % 2) == 1) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k < SP_DEPTH; k++) begin
      tbl[k] = sp_ln1p(y);
      y = (y * e) >> 30;
    end
    return tbl;
  endfunction

  localparam sp_table_t SOFTPLUS = sp_build();

endpackage

`default_nettype wire

### src/bscl_stream_if.sv
// ----------------------------------------------------------------------------
// bscl_stream_if
// Valid/ready channel carrying one word of a packed payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface bscl_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/bscl_label_mem.sv
// ----------------------------------------------------------------------------
// bscl_label_mem
// Single-port label store, one label per pixel, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bscl_label_mem
  import bscl_pkg::*;
#(
  parameter int DEPTH  = MAX_PIXELS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  addr,
  input  wire logic [LABEL_W-1:0] wdata,
  output logic      [LABEL_W-1:0] rdata
);

  logic [LABEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

### src/bscl_divider.sv
// ----------------------------------------------------------------------------
// bscl_divider
// Restoring divider for the class weights: (numer << 16) / denom with
// numer <= denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bscl_divider
  import bscl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEPS = WEIGHT_W;
  localparam int CNT_B = $clog2(STEPS);

  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    den;
  logic [WEIGHT_W-1:0] quot;
  logic [CNT_B-1:0]    step;
  logic                busy;
  logic                first;
  logic                done;

  logic [CNT_W:0] cand;
  logic           ge;

  // First step consumes the whole numerator, later steps shift in zeros.
  assign cand = first ? {1'b0, rem} : {rem, 1'b0};
  assign ge   = (cand >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (step == CNT_B'(STEPS - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.numer;
      den   <= req.denom;
      quot  <= '0;
      step  <= '0;
      first <= 1'b1;
    end else if (busy) begin
      rem   <= ge ? CNT_W'(cand - {1'b0, den}) : cand[CNT_W-1:0];
      quot  <= {quot[WEIGHT_W-2:0], ge};
      step  <= step + CNT_B'(1);
      first <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

### src/balanced_sigmoid_ce_loss.sv
// ----------------------------------------------------------------------------
// balanced_sigmoid_ce_loss
// Class-balanced sigmoid cross-entropy loss and gradient, fixed point.
// Channel item (sink) takes one word per op: func 0 loads a pixel label,
// func 1 accumulates the loss term of a logit, func 2 asks for a gradient.
// Channel result (source) returns gradient words (kind 0) and, on the last
// logit of a pass, the total loss word (kind 1). cfg_we/cfg_wdata write the
// number of label channels; write only while the block is idle.
// Work per item: a label is stored; a label with last also runs two 17-step
// weight divisions in one shared divider; a logit takes a label store read
// and a table add; one with last also uses a single 40x17 multiplier twice; a
// gradient takes two registered multiplies. One item is in work at a time; a
// finished word waits in the output register while the next item is taken,
// and a stalled receiver holds only the next word that needs that register.
// Reset (rst, synchronous) clears counts, weights, sums, the output valid
// and sets one label channel; the label store holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module balanced_sigmoid_ce_loss
  import bscl_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  bscl_stream_if.sink           item,
  bscl_stream_if.source         result
);

  localparam int PIX_SPAN  = 1 << PIXEL_W;
  localparam int PIX_DEPTH = (MAX_PIXELS < PIX_SPAN) ? MAX_PIXELS : PIX_SPAN;
  localparam int ADDR_W    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  localparam int IDX_W     = $clog2(SP_DEPTH);
  localparam int MUL_W     = SUM_W + WEIGHT_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_LOOKUP = 10'b00_0000_0010,
    S_GRAD2  = 10'b00_0000_0100,
    S_GRAD3  = 10'b00_0000_1000,
    S_LOSS1  = 10'b00_0001_0000,
    S_LOSS2  = 10'b00_0010_0000,
    S_LOSS3  = 10'b00_0100_0000,
    S_DIVP   = 10'b00_1000_0000,
    S_WAITP  = 10'b01_0000_0000,
    S_WAITN  = 10'b10_0000_0000
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    label_channels;
  logic [CNT_W-1:0]    positive_count;
  logic [CNT_W-1:0]    total_count;
  logic [WEIGHT_W-1:0] weight_positive;
  logic [WEIGHT_W-1:0] weight_negative;
  logic [SUM_W-1:0]    sum_positive;
  logic [SUM_W-1:0]    sum_negative;

  item_t               it;
  logic                it_in_range;
  logic signed [35:0]  grad_p1;
  logic signed [51:0]  grad_prod;
  logic [MUL_W-1:0]    loss_pa;
  logic [MUL_W-1:0]    loss_pb;
  logic                res_valid;
  result_t             res_data;

  // ---------------------------------------------------------------- intake
  logic accept;
  logic in_range_now;
  logic is_load;

  assign item.ready   = (state == S_IDLE);
  assign accept       = item.valid && item.ready;
  assign in_range_now = (32'(item.data.pixel) < 32'(MAX_PIXELS));
  assign is_load      = (item.data.func == FUNC_LOAD);

  logic               mem_en;
  logic               mem_we;
  logic [LABEL_W-1:0] mem_rdata;

  assign mem_we = accept && is_load;
  assign mem_en = accept && ((is_load && in_range_now) || (item.data.func == FUNC_FWD)
                             || (item.data.func == FUNC_BWD));

  bscl_label_mem #(
    .DEPTH  (PIX_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_label_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (item.data.pixel[ADDR_W-1:0]),
    .wdata (item.data.label),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- match
  logic [CFG_W-1:0]   nch;
  logic               in_use;
  logic [LABEL_W-1:0] stored;
  logic               positive;

  assign nch      = (label_channels > CFG_W'(MAX_CHANNELS)) ? CFG_W'(MAX_CHANNELS)
                                                            : label_channels;
  assign in_use   = (CFG_W'(it.channel) < nch);
  assign stored   = it_in_range ? mem_rdata : '0;
  assign positive = in_use && (stored == (LABEL_W'(it.channel) + LABEL_W'(1)));

  // ---------------------------------------------------------------- forward
  logic [LOGIT_W-1:0]         ax;
  logic [LOGIT_W:0]           ax_rnd;
  logic [LOGIT_W-4:0]         idx_full;
  logic [SP_W-1:0]            term;
  logic [LOGIT_W-1:0]         lin;
  logic [SUM_W-1:0]           addend;
  logic [SUM_W-1:0]           sum_sel;
  logic [SUM_W:0]             sum_raw;
  logic [SUM_W-1:0]           sum_sat;

  assign ax       = it.logit[LOGIT_W-1] ? LOGIT_W'(-it.logit) : LOGIT_W'(it.logit);
  assign ax_rnd   = {1'b0, ax} + (LOGIT_W+1)'(8);
  assign idx_full = ax_rnd[LOGIT_W:4];
  assign term     = (idx_full[LOGIT_W-4:IDX_W] == '0) ? SOFTPLUS[idx_full[IDX_W-1:0]] : '0;
  // the linear part only counts on the side of the wrong sign
  assign lin      = (positive == it.logit[LOGIT_W-1]) ? ax : '0;
  assign addend   = SUM_W'(term) + SUM_W'({lin, 8'b0});
  assign sum_sel  = positive ? sum_positive : sum_negative;
  assign sum_raw  = {1'b0, sum_sel} + {1'b0, addend};
  assign sum_sat  = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];

  // ---------------------------------------------------------------- backward
  logic signed [17:0] diff;
  logic signed [17:0] wsel;
  logic [51:0]        gmag;
  logic [51:0]        grnd;
  logic [GRAD_W-1:0]  gval;

  assign diff = {2'b00, it.prob} - (positive ? 18'h10000 : 18'h00000);
  assign wsel = {1'b0, (positive ? weight_positive : weight_negative)};
  assign gmag = grad_prod[51] ? 52'(-grad_prod) : 52'(grad_prod);
  assign grnd = gmag + (52'd1 << 23);
  assign gval = grad_prod[51] ? (GRAD_W'(0) - {4'b0, grnd[51:24]}) : {4'b0, grnd[51:24]};

  // ---------------------------------------------------------------- loss
  logic [SUM_W-1:0]    mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [MUL_W-1:0]    mul_res;
  logic [MUL_W:0]      loss_t;

  assign mul_a   = (state == S_LOSS1) ? sum_positive : sum_negative;
  assign mul_b   = (state == S_LOSS1) ? weight_positive : weight_negative;
  assign mul_res = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign loss_t  = {1'b0, loss_pa} + {1'b0, loss_pb} + (MUL_W+1)'(1 << 15);

  // ---------------------------------------------------------------- output
  logic    out_free;
  logic    out_load;
  result_t res_next;

  assign out_free = !res_valid || result.ready;
  assign out_load = out_free && ((state == S_GRAD3) || (state == S_LOSS3));

  always_comb begin
    res_next = '0;
    if (state == S_LOSS3) begin
      res_next.result_kind = KIND_LOSS;
      res_next.loss        = LOSS_W'(loss_t[MUL_W:16]);
    end else begin
      res_next.result_kind = KIND_GRAD;
      res_next.gradient    = gval;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

  // ---------------------------------------------------------------- weights
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start = ((state == S_DIVP) && (total_count != '0))
                    || ((state == S_WAITP) && div_rsp.done);
    div_req.numer = (state == S_DIVP) ? (total_count - positive_count) : positive_count;
    div_req.denom = total_count;
  end

  bscl_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      label_channels  <= CHANNELS_RST;
      positive_count  <= '0;
      total_count     <= '0;
      weight_positive <= '0;
      weight_negative <= '0;
      sum_positive    <= '0;
      sum_negative    <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        label_channels <= cfg_wdata;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if ((item.data.label != '0) && (positive_count != CNT_MAX)) begin
                positive_count <= positive_count + CNT_W'(1);
              end
              if (total_count != CNT_MAX) begin
                total_count <= total_count + CNT_W'(1);
              end
              if (item.data.last) begin
                state <= S_DIVP;
              end
            end else if ((item.data.func == FUNC_FWD) || (item.data.func == FUNC_BWD)) begin
              state <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          if (it.func == FUNC_FWD) begin
            if (in_use) begin
              if (positive) begin
                sum_positive <= sum_sat;
              end else begin
                sum_negative <= sum_sat;
              end
            end
            state <= it.last ? S_LOSS1 : S_IDLE;
          end else begin
            state <= S_GRAD2;
          end
        end
        S_GRAD2: state <= S_GRAD3;
        S_GRAD3: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_LOSS1: state <= S_LOSS2;
        S_LOSS2: state <= S_LOSS3;
        S_LOSS3: begin
          if (out_free) begin
            sum_positive <= '0;
            sum_negative <= '0;
            state        <= S_IDLE;
          end
        end
        S_DIVP: begin
          if (total_count == '0) begin
            weight_positive <= '0;
            weight_negative <= '0;
            state           <= S_IDLE;
          end else begin
            state <= S_WAITP;
          end
        end
        S_WAITP: begin
          if (div_rsp.done) begin
            weight_positive <= div_rsp.quot;
            state           <= S_WAITN;
          end
        end
        S_WAITN: begin
          if (div_rsp.done) begin
            weight_negative <= div_rsp.quot;
            positive_count  <= '0;
            total_count     <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      it          <= item.data;
      it_in_range <= in_range_now;
    end
    // an unused channel yields a zero product, hence a zero gradient
    if (state == S_LOOKUP) begin
      grad_p1 <= in_use ? (diff * wsel) : 36'sd0;
    end
    if (state == S_GRAD2) begin
      grad_prod <= grad_p1 * it.loss_scale;
    end
    if (state == S_LOSS1) begin
      loss_pa <= mul_res;
    end
    if (state == S_LOSS2) begin
      loss_pb <= mul_res;
    end
    if (out_load) begin
      res_data <= res_next;
    end
  end

  // ---------------------------------------------------------------- checks
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> ((state == S_WAITP) || (state == S_WAITN)))
    else $error("weight division finished outside a wait state");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    positive_count <= total_count)
    else $error("positive count exceeds total count");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOSS3) && out_free) |=> ((sum_positive == '0) && (sum_negative == '0)))
    else $error("loss sums not cleared after loss word");

endmodule

`default_nettype wire

### test/tb_balanced_sigmoid_ce_loss.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_balanced_sigmoid_ce_loss
// Streams label, logit and gradient words through the loss block, predicts
// every loss and gradient word from a bit-exact copy of the fixed-point
// arithmetic kept here, and checks each returned word in order. The random
// part runs well-formed label/forward passes under changing channel counts,
// with broken passes, ignored words and random stalls on both sides.
// ----------------------------------------------------------------------------

module tb_balanced_sigmoid_ce_loss;
  import bscl_pkg::*;

  localparam logic [1:0]      FUNC_NONE = 2'd3;
  localparam longint unsigned Q30_ONE_U = 64'd1 << 30;
  localparam longint unsigned SUM_TOP   = (64'd1 << 40) - 1;
  localparam longint unsigned LOSS_TOP  = (64'd1 << 48) - 1;
  localparam int              ITEM_GOAL = 1350;
  localparam int              SETTLE    = 64;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bscl_stream_if #(.data_t(item_t))   item_ch ();
  bscl_stream_if #(.data_t(result_t)) result_ch ();

  balanced_sigmoid_ce_loss uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch),
    .result   (result_ch)
  );

  // Shadow state of the loss block
  logic [15:0]       softplus_rom [256];
  logic [4:0]        label_mem [int];
  int unsigned       pos_cnt;
  int unsigned       tot_cnt;
  longint unsigned   w_pos;
  longint unsigned   w_neg;
  longint unsigned   sum_pos;
  longint unsigned   sum_neg;
  logic [CFG_W-1:0]  n_channels;

  result_t           loss_grad_due [$];
  item_t             item_backlog [$];

  // Stimulus-side view of the label store
  int                gen_label [int];
  int                written_px [$];
  int                phase_px [$];

  int pushed_n, accepted_n, stim_n, settings_n;
  int loads_n, logits_n, grads_n, ignored_n;
  int losses_seen, grads_seen, mismatches;
  int send_gap, stall_left, ticks;
  bit calm;

  function automatic void predict_loss_grad(input item_t it);
    logic [4:0]      stored;
    int unsigned     nch;
    bit              in_use;
    bit              pos;
    bit              neg;
    int              xs;
    int              ax;
    int              idx;
    longint unsigned term;
    longint unsigned lin;
    longint unsigned add_v;
    longint unsigned t;
    longint unsigned lossv;
    longint unsigned mag;
    longint unsigned r;
    longint          diff;
    longint          w;
    longint          sc;
    longint          prod;
    longint          g;
    result_t         rw;
    nch = (n_channels > MAX_CHANNELS) ? MAX_CHANNELS : n_channels;
    in_use = it.channel < nch;
    stored = label_mem.exists(int'(it.pixel)) ? label_mem[int'(it.pixel)] : 5'd0;
    pos = in_use && (stored == it.channel + 1);
    case (it.func)
      FUNC_LOAD: begin
        loads_n++;
        label_mem[int'(it.pixel)] = it.label;
        if (it.label != 0 && pos_cnt < CNT_MAX) pos_cnt++;
        if (tot_cnt < CNT_MAX) tot_cnt++;
        if (it.last) begin
          if (tot_cnt != 0) begin
            w_pos = (longint'(tot_cnt - pos_cnt) << 16) / tot_cnt;
            w_neg = (longint'(pos_cnt) << 16) / tot_cnt;
          end else begin
            w_pos = 0;
            w_neg = 0;
          end
          pos_cnt = 0;
          tot_cnt = 0;
        end
      end
      FUNC_FWD: begin
        logits_n++;
        if (in_use) begin
          xs = $signed(it.logit);
          ax = (xs < 0) ? -xs : xs;
          idx = (ax + 8) >> 4;
          term = (idx < 256) ? 64'(softplus_rom[idx]) : 64'd0;
          if (pos) lin = (xs < 0) ? -xs : 0;
          else lin = (xs > 0) ? xs : 0;
          add_v = term + (lin << 8);
          if (pos) sum_pos = (sum_pos + add_v > SUM_TOP) ? SUM_TOP : sum_pos + add_v;
          else sum_neg = (sum_neg + add_v > SUM_TOP) ? SUM_TOP : sum_neg + add_v;
        end
        if (it.last) begin
          t = sum_pos * w_pos + sum_neg * w_neg;
          lossv = (t + (64'd1 << 15)) >> 16;
          if (lossv > LOSS_TOP) lossv = LOSS_TOP;
          rw.result_kind = KIND_LOSS;
          rw.gradient = '0;
          rw.loss = lossv[47:0];
          loss_grad_due = {loss_grad_due, rw};
          sum_pos = 0;
          sum_neg = 0;
        end
      end
      FUNC_BWD: begin
        grads_n++;
        g = 0;
        if (in_use) begin
          diff = longint'(it.prob) - (pos ? 65536 : 0);
          w = pos ? longint'(w_pos) : longint'(w_neg);
          sc = $signed(it.loss_scale);
          prod = diff * w * sc;
          neg = prod < 0;
          mag = neg ? -prod : prod;
          r = (mag + (64'd1 << 23)) >> 24;
          if (r > 64'd2147483648) r = 64'd2147483648;
          if (!neg && r > 64'd2147483647) r = 64'd2147483647;
          g = neg ? -longint'(r) : longint'(r);
        end
        rw.result_kind = KIND_GRAD;
        rw.gradient = g[31:0];
        rw.loss = '0;
        loss_grad_due = {loss_grad_due, rw};
      end
      default: ignored_n++;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 85) return $urandom_range(1, n_channels);
    if (r < 95) return $urandom_range(1, 16);
    return $urandom_range(17, 31);
  endfunction

  function automatic int pick_pixel();
    if (written_px.size() == 0) return 0;
    if (phase_px.size() != 0 && $urandom_range(0, 9) != 0)
      return phase_px[$urandom_range(0, phase_px.size() - 1)];
    return written_px[$urandom_range(0, written_px.size() - 1)];
  endfunction

  // Aim at the matching channel often so positives show up
  function automatic int pick_channel(input int px);
    int r;
    int lb;
    r = $urandom_range(0, 99);
    lb = gen_label.exists(px) ? gen_label[px] : 0;
    if (r < 45 && lb >= 1 && lb <= 16) return lb - 1;
    if (r < 85) return $urandom_range(0, n_channels - 1);
    return $urandom_range(0, 15);
  endfunction

  function automatic int pick_logit();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65535) - 32768;
      1: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $urandom_range(0, 8400) - 4200;
    endcase
  endfunction

  function automatic int pick_prob();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int pick_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return -32768;
    if (r < 20) return 32767;
    if (r < 25) return 0;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int rnd16();
    return $urandom_range(0, 65535);
  endfunction

  task automatic push_item(input logic [1:0] f, input int px, input int ch, input int lb,
                           input int lg, input int pr, input int sc, input bit lst);
    item_t it;
    it.func = f;
    it.pixel = px[15:0];
    it.channel = ch[3:0];
    it.label = lb[4:0];
    it.logit = lg[15:0];
    it.prob = pr[15:0];
    it.loss_scale = sc[15:0];
    it.last = lst;
    if (f == FUNC_LOAD) begin
      if (!gen_label.exists(px)) written_px = {written_px, px};
      gen_label[px] = lb;
    end
    item_backlog = {item_backlog, it};
    pushed_n++;
    if (f != FUNC_NONE) stim_n++;
  endtask

  // Hold until every word went in and every result came back, then let
  // a weight division with no result finish.
  task automatic wait_idle();
    while (accepted_n != pushed_n || loss_grad_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_channels(input int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    n_channels = v[4:0];
    settings_n++;
  endtask

  task automatic push_grad();
    int px;
    px = pick_pixel();
    push_item(FUNC_BWD, px, pick_channel(px), pick_label(), pick_logit(), pick_prob(),
              pick_scale(), $urandom_range(0, 1));
  endtask

  task automatic push_noise();
    push_item(FUNC_NONE, rnd16(), $urandom_range(0, 15), $urandom_range(0, 31),
              pick_logit(), rnd16(), pick_scale(), $urandom_range(0, 1));
  endtask

  // One label pass, then a forward pass over those pixels with gradient
  // words mixed in; now and then drop a last to break the pass.
  task automatic gen_phase();
    int n_px;
    int n_fwd;
    int px;
    bit keep_last;
    phase_px.delete();
    n_px = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 48);
    keep_last = $urandom_range(0, 19) != 0;
    for (int i = 0; i < n_px; i++) begin
      px = rnd16();
      phase_px = {phase_px, px};
      if ($urandom_range(0, 29) == 0) push_noise();
      push_item(FUNC_LOAD, px, $urandom_range(0, 15), pick_label(), pick_logit(),
                rnd16(), pick_scale(), keep_last && i == n_px - 1);
    end
    n_fwd = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 60);
    keep_last = $urandom_range(0, 9) != 0;
    for (int j = 0; j < n_fwd; j++) begin
      if ($urandom_range(0, 99) < 30) push_grad();
      if ($urandom_range(0, 29) == 0) push_noise();
      px = pick_pixel();
      push_item(FUNC_FWD, px, pick_channel(px), pick_label(), pick_logit(), rnd16(),
                pick_scale(), keep_last && j == n_fwd - 1);
    end
    repeat ($urandom_range(0, 4)) push_grad();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: present the backlog one word at a time
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_loss_grad(item_ch.data);
        accepted_n++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          item_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (item_backlog.size() != 0) begin
          item_ch.valid <= 1'b1;
          item_ch.data <= item_backlog.pop_front();
          send_gap <= pick_gap();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each word against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (loss_grad_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word kind %0d grad %0d loss %0d", $realtime,
                     got.result_kind, got.gradient, got.loss);
        end else begin
          want = loss_grad_due.pop_front();
          if (want.result_kind == KIND_LOSS) losses_seen++;
          else grads_seen++;
          if (got.result_kind !== want.result_kind || got.gradient !== want.gradient ||
              got.loss !== want.loss) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch kind %0d/%0d grad %0d/%0d loss %0d/%0d (exp/act)",
                       $realtime, want.result_kind, got.result_kind, want.gradient,
                       got.gradient, want.loss, got.loss);
          end
        end
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        result_ch.ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Switch between stretches with and without idling
  always @(posedge clk) begin
    if (rst) begin
      calm <= 1'b0;
      ticks <= 0;
    end else begin
      ticks <= ticks + 1;
      if (ticks % 400 == 399) calm <= $urandom_range(0, 3) == 0;
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d of %0d words accepted, %0d results outstanding",
             accepted_n, pushed_n, loss_grad_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    longint unsigned e;
    longint unsigned term;
    longint unsigned y;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned acc;
    longint unsigned rr;
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;

    // Softplus ROM: exp(-1/16) by series, then ln(1+y) = 2*atanh(y/(2+y))
    e = Q30_ONE_U;
    term = Q30_ONE_U;
    y = Q30_ONE_U;
    for (int n = 1; n <= 12; n++) begin
      term = term / 64'(16 * n);
      if (n % 2 == 1) e = e - term;
      else e = e + term;
    end
    for (int k = 0; k < 256; k++) begin
      z = (y << 30) / ((Q30_ONE_U << 1) + y);
      z2 = (z * z) >> 30;
      p = z;
      acc = 0;
      for (int m = 1; m < 200 && p != 0; m += 2) begin
        acc = acc + p / 64'(m);
        p = (p * z2) >> 30;
      end
      rr = ((acc << 1) + (64'd1 << 13)) >> 14;
      softplus_rom[k] = (rr > 65535) ? 16'hFFFF : rr[15:0];
      y = (y * e) >> 30;
    end

    pos_cnt = 0;
    tot_cnt = 0;
    w_pos = 0;
    w_neg = 0;
    sum_pos = 0;
    sum_neg = 0;
    n_channels = CHANNELS_RST;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one channel in use after reset
    push_item(FUNC_LOAD, 0, 0, 1, 0, 0, 0, 0);
    push_item(FUNC_LOAD, 65535, 15, 0, 0, 0, 0, 0);
    push_item(FUNC_LOAD, 100, 0, 31, 0, 0, 0, 0);       // high label never matches
    push_item(FUNC_LOAD, 200, 0, 16, 0, 0, 0, 0);
    push_item(FUNC_LOAD, 300, 0, 17, 0, 0, 0, 0);
    push_item(FUNC_LOAD, 4660, 0, 5, 0, 0, 0, 1);
    push_item(FUNC_FWD, 0, 0, 0, -32768, 0, 0, 0);
    push_item(FUNC_FWD, 65535, 0, 0, 32767, 0, 0, 0);
    push_item(FUNC_FWD, 200, 0, 0, 0, 0, 0, 0);
    push_item(FUNC_FWD, 100, 5, 0, 100, 0, 0, 0);       // channel not in use
    push_item(FUNC_FWD, 300, 0, 0, -1, 0, 0, 0);
    push_item(FUNC_FWD, 0, 0, 0, 8, 0, 0, 1);
    push_item(FUNC_BWD, 0, 0, 0, 0, 0, -32768, 0);
    push_item(FUNC_BWD, 0, 0, 0, 0, 65535, 32767, 0);
    push_item(FUNC_BWD, 65535, 0, 0, 0, 65535, -1, 0);
    push_item(FUNC_BWD, 200, 15, 0, 0, 1234, 256, 1);  // unused channel, last ignored
    push_item(FUNC_NONE, 0, 0, 1, 1000, 65535, 32767, 1);
    push_item(FUNC_FWD, 200, 9, 0, 77, 0, 0, 1);        // loss with nothing added
    wait_idle();

    // Directed: all sixteen channels, top channel positive
    set_channels(MAX_CHANNELS);
    push_item(FUNC_LOAD, 0, 0, 1, 0, 0, 0, 0);
    push_item(FUNC_LOAD, 200, 0, 16, 0, 0, 0, 1);
    push_item(FUNC_FWD, 200, 15, 0, -5, 0, 0, 0);
    push_item(FUNC_FWD, 0, 0, 0, 1000, 0, 0, 1);
    push_item(FUNC_BWD, 200, 15, 0, 0, 0, 32767, 0);

    phase = 0;
    while (stim_n < ITEM_GOAL) begin
      wait_idle();
      case (phase % 5)
        0: set_channels(1);
        1: set_channels(MAX_CHANNELS);
        default: set_channels($urandom_range(1, MAX_CHANNELS));
      endcase
      gen_phase();
      phase++;
    end

    wait_idle();
    if (loss_grad_due.size() != 0) mismatches++;
    $display("Sent %0d label, %0d logit, %0d gradient and %0d ignored words under %0d",
             loads_n, logits_n, grads_n, ignored_n, settings_n);
    $display("channel settings; checked %0d loss and %0d gradient words, %0d mismatches",
             losses_seen, grads_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
